FILE: hw/rtl/spq_pkg.sv
// Package for the sorted priority queue: capacity, widths, operation and
// status codes, controller states and the command/status structs.
// No dependencies.
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int OP_W     = 2;
   localparam int HDL_W    = 16;
   localparam int PRIO_W   = 32;
   localparam int STAT_W   = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_EXTRACT  = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_DECREASE = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REMOVE,
      S_INSERT,
      S_HOLD
   } state_type;

   typedef struct packed {
      logic load;
      logic remove;
      logic insert;
      logic rsp_next;
      logic rsp_held;
   } cmd_type;

   typedef struct packed {
      op_type op;
   } stat_type;

endpackage

FILE: hw/rtl/spq_datapath.sv
// Datapath of the sorted priority queue: the sorted shift-register array,
// the entry count, the request latch and the result register.
// Depends on spq_pkg.
module spq_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [spq_pkg::OP_W-1:0]         req_operation,
   input  logic [spq_pkg::HDL_W-1:0]        req_item_handle,
   input  logic signed [spq_pkg::PRIO_W-1:0] req_priority_req,
   input  spq_pkg::cmd_type                 cmd,
   output spq_pkg::stat_type                stat,
   output logic [spq_pkg::HDL_W-1:0]        rsp_out_handle,
   output logic [spq_pkg::STAT_W-1:0]       rsp_status,
   output logic [spq_pkg::OCC_W-1:0]        rsp_occupancy
);

   localparam int N = spq_pkg::CAPACITY;

   spq_pkg::op_type                   op_ff, op_in;
   logic [spq_pkg::HDL_W-1:0]         handle_ff, handle_in;
   logic signed [spq_pkg::PRIO_W-1:0] prio_ff, prio_in;
   spq_pkg::status_type               status_ff, status_in;
   logic [spq_pkg::HDL_W-1:0]         got_ff, got_in;
   logic [spq_pkg::CNT_W-1:0]         count_ff, count_in;
   logic signed [spq_pkg::PRIO_W-1:0] prio_mem_ff [N];
   logic signed [spq_pkg::PRIO_W-1:0] prio_mem_in [N];
   logic [spq_pkg::HDL_W-1:0]         hdl_mem_ff [N];
   logic [spq_pkg::HDL_W-1:0]         hdl_mem_in [N];
   logic [spq_pkg::HDL_W-1:0]         rsp_handle_ff, rsp_handle_in;
   spq_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [spq_pkg::OCC_W-1:0]         rsp_occ_ff, rsp_occ_in;

   logic [N-1:0] match;
   logic [N-1:0] past_match;
   logic [N-1:0] greater;
   logic [N-1:0] shift_up;
   logic         found;
   logic         full;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (op_ff == spq_pkg::OP_EXTRACT) begin
            match[i] = (i == 0) && (count_ff != '0);
         end else begin
            match[i] = (spq_pkg::CNT_W'(i) < count_ff) && (hdl_mem_ff[i] == handle_ff);
         end
         greater[i] = (spq_pkg::CNT_W'(i) < count_ff) && (prio_mem_ff[i] > prio_ff);
         shift_up[i] = greater[i] || (spq_pkg::CNT_W'(i) == count_ff);
      end
      past_match[0] = match[0];
      for (int i = 1; i < N; i++) begin
         past_match[i] = past_match[i-1] | match[i];
      end
      found = |match;
      full  = (count_ff == spq_pkg::CNT_W'(N));
   end

   always_comb begin
      op_in     = op_ff;
      handle_in = handle_ff;
      prio_in   = prio_ff;
      status_in = status_ff;
      got_in    = got_ff;
      count_in  = count_ff;
      for (int i = 0; i < N; i++) begin
         prio_mem_in[i] = prio_mem_ff[i];
         hdl_mem_in[i]  = hdl_mem_ff[i];
      end

      if (cmd.load) begin
         op_in     = spq_pkg::op_type'(req_operation);
         handle_in = req_item_handle;
         prio_in   = req_priority_req;
         status_in = spq_pkg::ST_OK;
         got_in    = '0;
      end

      if (cmd.remove) begin
         for (int i = 0; i < N - 1; i++) begin
            if (past_match[i]) begin
               prio_mem_in[i] = prio_mem_ff[i+1];
               hdl_mem_in[i]  = hdl_mem_ff[i+1];
            end
         end
         if (found) begin
            count_in = count_ff - 1'b1;
         end
         if (op_ff == spq_pkg::OP_EXTRACT) begin
            if (found) begin
               got_in = hdl_mem_ff[0];
            end else begin
               status_in = spq_pkg::ST_EMPTY;
            end
         end else if (op_ff == spq_pkg::OP_REMOVE && !found) begin
            status_in = spq_pkg::ST_NOT_FOUND;
         end
      end

      if (cmd.insert) begin
         if (full) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            for (int i = 0; i < N; i++) begin
               if (shift_up[i] && !(i > 0 && shift_up[(i > 0) ? i - 1 : 0])) begin
                  prio_mem_in[i] = prio_ff;
                  hdl_mem_in[i]  = handle_ff;
               end else if (shift_up[i]) begin
                  prio_mem_in[i] = prio_mem_ff[(i > 0) ? i - 1 : 0];
                  hdl_mem_in[i]  = hdl_mem_ff[(i > 0) ? i - 1 : 0];
               end
            end
            count_in = count_ff + 1'b1;
            status_in = spq_pkg::ST_OK;
         end
      end
   end

   always_comb begin
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (cmd.rsp_next) begin
         rsp_handle_in = got_in;
         rsp_status_in = status_in;
         rsp_occ_in    = spq_pkg::OCC_W'(count_in);
      end else if (cmd.rsp_held) begin
         rsp_handle_in = got_ff;
         rsp_status_in = status_ff;
         rsp_occ_in    = spq_pkg::OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      handle_ff     <= handle_in;
      prio_ff       <= prio_in;
      status_ff     <= status_in;
      got_ff        <= got_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
      for (int i = 0; i < N; i++) begin
         prio_mem_ff[i] <= prio_mem_in[i];
         hdl_mem_ff[i]  <= hdl_mem_in[i];
      end
   end

   assign stat.op        = op_ff;
   assign rsp_out_handle = rsp_handle_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule

FILE: hw/rtl/spq_controller.sv
// Controller of the sorted priority queue: sequences the remove and insert
// phases of one request and owns the result valid flag.
// Depends on spq_pkg.
module spq_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [spq_pkg::OP_W-1:0] req_operation,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  spq_pkg::stat_type        stat,
   output spq_pkg::cmd_type         cmd
);

   spq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               last_phase;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_phase = (state_ff == spq_pkg::S_INSERT) ||
                       (state_ff == spq_pkg::S_REMOVE && stat.op != spq_pkg::OP_DECREASE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            if (req_valid) begin
               if (spq_pkg::op_type'(req_operation) == spq_pkg::OP_INSERT) begin
                  state_in = spq_pkg::S_INSERT;
               end else begin
                  state_in = spq_pkg::S_REMOVE;
               end
            end
         end
         spq_pkg::S_REMOVE: begin
            if (stat.op == spq_pkg::OP_DECREASE) begin
               state_in = spq_pkg::S_INSERT;
            end else if (out_free) begin
               state_in = spq_pkg::S_IDLE;
            end else begin
               state_in = spq_pkg::S_HOLD;
            end
         end
         spq_pkg::S_INSERT: begin
            state_in = out_free ? spq_pkg::S_IDLE : spq_pkg::S_HOLD;
         end
         spq_pkg::S_HOLD: begin
            if (out_free) begin
               state_in = spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         spq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         spq_pkg::S_REMOVE: begin
            cmd.remove   = 1'b1;
            cmd.rsp_next = last_phase && out_free;
         end
         spq_pkg::S_INSERT: begin
            cmd.insert   = 1'b1;
            cmd.rsp_next = out_free;
         end
         spq_pkg::S_HOLD: begin
            cmd.rsp_held = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_next || cmd.rsp_held) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: joins the controller and datapath.
// Depends on spq_pkg, spq_controller and spq_datapath.
//
// Usage: a request beat on the req_ channel carries an operation (insert,
// extract minimum, remove handle, decrease key), a handle and a signed Q16.16
// priority. Every request yields exactly one response beat on the rsp_
// channel with the extracted handle, a status code and the occupancy after
// the operation. Entries are kept sorted in a shift-register array, so each
// phase compares all entries in parallel.
// For insert, extract and remove the response beat is registered at the end
// of the single array phase; for decrease key at the end of the insert phase,
// after a remove phase. One request is handled at a time and the block is ready
// again after its last phase; each request takes an accept cycle and then its
// array phases.
// The response register lets a new request be accepted while the previous
// response waits; if the receiver still stalls when the next response is
// ready, the block holds that response internally and accepts nothing more.
// Reset empties the queue and drops any pending response.
module sorted_priority_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [spq_pkg::OP_W-1:0]          req_operation,
   input  logic [spq_pkg::HDL_W-1:0]         req_item_handle,
   input  logic signed [spq_pkg::PRIO_W-1:0] req_priority_req,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spq_pkg::HDL_W-1:0]         rsp_out_handle,
   output logic [spq_pkg::STAT_W-1:0]        rsp_status,
   output logic [spq_pkg::OCC_W-1:0]         rsp_occupancy
);

   spq_pkg::cmd_type  cmd;
   spq_pkg::stat_type stat;

   spq_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   spq_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_item_handle  (req_item_handle),
      .req_priority_req (req_priority_req),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule

FILE: hw/rtl/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [spq_pkg::OP_W-1:0]          req_operation,
   input logic [spq_pkg::HDL_W-1:0]         req_item_handle,
   input logic signed [spq_pkg::PRIO_W-1:0] req_priority_req,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [spq_pkg::HDL_W-1:0]         rsp_out_handle,
   input logic [spq_pkg::STAT_W-1:0]        rsp_status,
   input logic [spq_pkg::OCC_W-1:0]         rsp_occupancy
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_operation) &&
      $stable(req_item_handle) && $stable(req_priority_req))
      else $error("request beat changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_handle) &&
      $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("response beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::ST_FULL |->
      rsp_occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY) && rsp_out_handle == '0)
      else $error("full status without a full queue");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::ST_EMPTY |->
      rsp_occupancy == '0 && rsp_out_handle == '0)
      else $error("empty status with entries or a handle");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

FILE: sim/tb_sorted_priority_queue.sv
// Self-checking testbench for sorted_priority_queue: a directed sweep and then
// random insert/extract/remove/decrease-key traffic, all checked against a sorted
// shadow list. Depends on spq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

   localparam int STALL_LIMIT = 2000;
   localparam int CALM_FIRST  = 300;
   localparam int CALM_LAST   = 420;
   localparam logic signed [spq_pkg::PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;
   localparam logic signed [spq_pkg::PRIO_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [spq_pkg::PRIO_W-1:0] PRIO_ONE = 32'sh0001_0000;

   typedef struct {
      spq_pkg::op_type                   op;
      logic [spq_pkg::HDL_W-1:0]         hdl;
      logic signed [spq_pkg::PRIO_W-1:0] prio;
      bit                                drain_first;
   } request_type;

   typedef struct packed {
      logic [spq_pkg::HDL_W-1:0] out_handle;
      spq_pkg::status_type       status;
      logic [spq_pkg::OCC_W-1:0] occupancy;
   } rsp_beat_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [spq_pkg::OP_W-1:0]          req_operation = '0;
   logic [spq_pkg::HDL_W-1:0]         req_item_handle = '0;
   logic signed [spq_pkg::PRIO_W-1:0] req_priority_req = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [spq_pkg::HDL_W-1:0]         rsp_out_handle;
   logic [spq_pkg::STAT_W-1:0]        rsp_status;
   logic [spq_pkg::OCC_W-1:0]         rsp_occupancy;

   request_type  pending_requests[$];
   rsp_beat_type expected_rsp[int];
   int           req_count = 0;
   int           rsp_count = 0;
   int           error_count = 0;
   int           idle_cycles = 0;
   int           op_seen[4] = '{default: 0};
   int           status_seen[4] = '{default: 0};

   logic signed [spq_pkg::PRIO_W-1:0] list_prio[spq_pkg::CAPACITY];
   logic [spq_pkg::HDL_W-1:0]         list_hdl[spq_pkg::CAPACITY];
   int                                list_len = 0;

   sorted_priority_queue i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_item_handle  (req_item_handle),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_handle   (rsp_out_handle),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // A new entry goes behind every entry of equal or smaller priority.
   function automatic spq_pkg::status_type list_insert(
      input logic [spq_pkg::HDL_W-1:0] hdl,
      input logic signed [spq_pkg::PRIO_W-1:0] prio);
      int pos;
      int i;
      if (list_len >= spq_pkg::CAPACITY) return spq_pkg::ST_FULL;
      pos = 0;
      while (pos < list_len && list_prio[pos] <= prio) pos++;
      for (i = list_len; i > pos; i--) begin
         list_prio[i] = list_prio[i-1];
         list_hdl[i]  = list_hdl[i-1];
      end
      list_prio[pos] = prio;
      list_hdl[pos]  = hdl;
      list_len++;
      return spq_pkg::ST_OK;
   endfunction

   function automatic void list_drop(input int pos);
      int i;
      for (i = pos; i + 1 < list_len; i++) begin
         list_prio[i] = list_prio[i+1];
         list_hdl[i]  = list_hdl[i+1];
      end
      list_len--;
   endfunction

   function automatic bit list_remove(input logic [spq_pkg::HDL_W-1:0] hdl);
      int i;
      for (i = 0; i < list_len; i++) begin
         if (list_hdl[i] == hdl) begin
            list_drop(i);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_beat_type queue_op_result(
      input spq_pkg::op_type op,
      input logic [spq_pkg::HDL_W-1:0] hdl,
      input logic signed [spq_pkg::PRIO_W-1:0] prio);
      rsp_beat_type res;
      res.out_handle = '0;
      res.status     = spq_pkg::ST_OK;
      case (op)
         spq_pkg::OP_INSERT: begin
            res.status = list_insert(hdl, prio);
         end
         spq_pkg::OP_EXTRACT: begin
            if (list_len == 0) begin
               res.status = spq_pkg::ST_EMPTY;
            end else begin
               res.out_handle = list_hdl[0];
               list_drop(0);
            end
         end
         spq_pkg::OP_REMOVE: begin
            if (!list_remove(hdl)) res.status = spq_pkg::ST_NOT_FOUND;
         end
         default: begin
            void'(list_remove(hdl));
            res.status = list_insert(hdl, prio);
         end
      endcase
      res.occupancy = spq_pkg::OCC_W'(list_len);
      return res;
   endfunction

   task automatic add_request(input spq_pkg::op_type op,
                              input logic [spq_pkg::HDL_W-1:0] hdl,
                              input logic signed [spq_pkg::PRIO_W-1:0] prio);
      request_type r;
      r.op          = op;
      r.hdl         = hdl;
      r.prio        = prio;
      r.drain_first = 1'b0;
      pending_requests.push_back(r);
   endtask

   task automatic add_drain_pause();
      request_type r;
      r.op          = spq_pkg::OP_INSERT;
      r.hdl         = '0;
      r.prio        = '0;
      r.drain_first = 1'b1;
      pending_requests.push_back(r);
   endtask

   // Mostly a small set of handles so that removes and re-keys find their target.
   function automatic logic [spq_pkg::HDL_W-1:0] pick_handle();
      if ($urandom_range(0, 99) < 70) return spq_pkg::HDL_W'($urandom_range(0, 9));
      return spq_pkg::HDL_W'($urandom());
   endfunction

   // Clustered priorities produce ties; the rest spans the whole signed range.
   function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return ($urandom_range(0, 1) == 0) ? PRIO_MIN : PRIO_MAX;
      if (r < 50) return spq_pkg::PRIO_W'($urandom_range(0, 4) - 2) << 16;
      return $urandom();
   endfunction

   function automatic spq_pkg::op_type pick_op(input int bias);
      int r;
      int t_ins;
      int t_dec;
      int t_rem;
      r = $urandom_range(0, 99);
      case (bias)
         0: begin
            t_ins = 55; t_dec = 75; t_rem = 88;
         end
         1: begin
            t_ins = 20; t_dec = 30; t_rem = 50;
         end
         default: begin
            t_ins = 25; t_dec = 50; t_rem = 75;
         end
      endcase
      if (r < t_ins) return spq_pkg::OP_INSERT;
      if (r < t_dec) return spq_pkg::OP_DECREASE;
      if (r < t_rem) return spq_pkg::OP_REMOVE;
      return spq_pkg::OP_EXTRACT;
   endfunction

   // Request driver: predicts each accepted beat and presents the next one.
   always @(posedge clock) begin
      request_type nxt;
      logic        fire;
      logic        send;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            expected_rsp[req_count] = queue_op_result(spq_pkg::op_type'(req_operation),
                                                      req_item_handle, req_priority_req);
            op_seen[req_operation]++;
            req_count <= req_count + 1;
         end
         if (!req_valid || fire) begin
            send = 1'b0;
            if (pending_requests.size() > 0 && pending_requests[0].drain_first) begin
               if (!req_valid && req_count == rsp_count) void'(pending_requests.pop_front());
            end else if (pending_requests.size() > 0) begin
               send = (req_count >= CALM_FIRST && req_count < CALM_LAST) ||
                      ($urandom_range(0, 99) >= 38);
            end
            if (send) begin
               nxt = pending_requests.pop_front();
               req_operation    <= nxt.op;
               req_item_handle  <= nxt.hdl;
               req_priority_req <= nxt.prio;
            end
            req_valid <= send;
         end
      end
   end

   // Response monitor: compares each beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_beat_type exp_beat;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_count >= req_count) begin
               $error("Response beat with no request outstanding: handle %h status %0d",
                      rsp_out_handle, rsp_status);
               error_count++;
            end else begin
               exp_beat = expected_rsp[rsp_count];
               expected_rsp.delete(rsp_count);
               if (rsp_out_handle !== exp_beat.out_handle) begin
                  $error("out_handle: expected %h, got %h", exp_beat.out_handle, rsp_out_handle);
                  error_count++;
               end
               if (rsp_status !== exp_beat.status) begin
                  $error("status: expected %0d, got %0d", exp_beat.status, rsp_status);
                  error_count++;
               end
               if (rsp_occupancy !== exp_beat.occupancy) begin
                  $error("occupancy: expected %0d, got %0d", exp_beat.occupancy, rsp_occupancy);
                  error_count++;
               end
               status_seen[exp_beat.status]++;
               rsp_count <= rsp_count + 1;
            end
         end
         rsp_ready <= (rsp_count >= CALM_FIRST && rsp_count < CALM_LAST) ||
                      ($urandom_range(0, 99) >= 38);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat accepted for %0d cycles.", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int k;
      add_request(spq_pkg::OP_EXTRACT, 16'h0005, '0);
      add_request(spq_pkg::OP_REMOVE, 16'h0005, '0);
      add_request(spq_pkg::OP_DECREASE, 16'h0007, PRIO_ONE);
      add_request(spq_pkg::OP_INSERT, 16'hFFFF, PRIO_MAX);
      add_request(spq_pkg::OP_INSERT, 16'h0000, PRIO_MIN);
      add_request(spq_pkg::OP_INSERT, 16'h0003, PRIO_ONE);
      add_request(spq_pkg::OP_INSERT, 16'h0003, PRIO_ONE);
      for (k = 0; k < 11; k++) begin
         add_request(spq_pkg::OP_INSERT, spq_pkg::HDL_W'(10 + k),
                     (k % 2 == 0) ? -PRIO_ONE : 32'sh0002_8000);
      end
      add_request(spq_pkg::OP_INSERT, 16'h0015, '0);
      add_request(spq_pkg::OP_DECREASE, 16'h0003, -2 * PRIO_ONE);
      add_request(spq_pkg::OP_DECREASE, 16'h0063, '0);
      add_request(spq_pkg::OP_DECREASE, 16'h0000, PRIO_MAX);
      add_request(spq_pkg::OP_REMOVE, 16'hFFFF, '0);
      add_request(spq_pkg::OP_REMOVE, 16'hFFFF, '0);
      add_request(spq_pkg::OP_EXTRACT, '0, '0);
      add_drain_pause();
      for (k = 0; k < 700; k++) begin
         if (k > 0 && k % 200 == 0) add_drain_pause();
         add_request(pick_op((k / 40) % 3), pick_handle(), pick_priority());
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || req_valid || rsp_count != req_count) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("Ran %0d requests (%0d insert, %0d extract, %0d remove, %0d decrease-key).",
               req_count, op_seen[spq_pkg::OP_INSERT], op_seen[spq_pkg::OP_EXTRACT],
               op_seen[spq_pkg::OP_REMOVE], op_seen[spq_pkg::OP_DECREASE]);
      $display("Responses: %0d ok, %0d empty, %0d not found, %0d full.",
               status_seen[spq_pkg::ST_OK], status_seen[spq_pkg::ST_EMPTY],
               status_seen[spq_pkg::ST_NOT_FOUND], status_seen[spq_pkg::ST_FULL]);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
